/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check is clocked on the rising
// edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

/* rtl/msps_pkg.sv */
package msps_pkg;

   localparam int NUM_SLOTS = 8;

   localparam int SLOT_W  = 3;
   localparam int CMD_W   = 2;
   localparam int PRIO_W  = 8;
   localparam int MASK_W  = 8;
   localparam int AGE_W   = 16;
   localparam int SLICE_W = 9;
   localparam int MODE_W  = 2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_STRATEGY_MODE = CSR_IDX_W'(0);

   typedef enum logic [CMD_W-1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_START    = 2'd1,
      CMD_RESET    = 2'd2
   } cmd_code_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_EVEN   = 2'd0,
      MODE_RR     = 2'd1,
      MODE_AGING  = 2'd2,
      MODE_RTC    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EVEN,
      ST_AGE,
      ST_AGE_FIN,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_SLICE_LOAD_CUR,
      OP_AGE_CLEAR,
      OP_RESULT_CUR,
      OP_EVEN_INIT,
      OP_EVEN_STEP,
      OP_AGE_INIT,
      OP_AGE_STEP,
      OP_AGE_FIN
   } dp_op_type;

   typedef struct packed {
      logic      take_in;
      dp_op_type op;
      logic      slice_tick;
      logic      slice_on_pick;
      logic      out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             cur_run;
      logic             cur_zero;
      logic             slice_expire;
      logic             even_done;
      logic             age_last;
      logic             out_busy;
   } dp_status_type;

endpackage

/* rtl/msps_req_if.sv */
interface msps_req_if import msps_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [SLOT_W-1:0] slot;
   logic [PRIO_W-1:0] priority_req;
   logic [MASK_W-1:0] runnable_mask;
   logic [SLOT_W-1:0] current;

   modport source (output valid, cmd, slot, priority_req, runnable_mask, current,
                   input ready);
   modport sink (input valid, cmd, slot, priority_req, runnable_mask, current,
                 output ready);
endinterface

/* rtl/msps_rsp_if.sv */
interface msps_rsp_if import msps_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] next_slot;

   modport source (output valid, next_slot, input ready);
   modport sink (input valid, next_slot, output ready);
endinterface

/* rtl/msps_ctrl.sv */
module msps_ctrl import msps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  mode_type      mode,
   input  dp_status_type dp_status,
   output logic          req_ready,
   output ctrl_cmd_type  ctrl_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in               = state_ff;
      req_ready              = 1'b0;
      ctrl_cmd.take_in       = 1'b0;
      ctrl_cmd.op            = OP_NONE;
      ctrl_cmd.slice_tick    = 1'b0;
      ctrl_cmd.slice_on_pick = 1'b0;
      ctrl_cmd.out_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.take_in = 1'b1;
               state_in         = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_FINISH;
            unique case (dp_status.cmd)
               CMD_SCHEDULE: begin
                  unique case (mode)
                     MODE_EVEN: begin
                        ctrl_cmd.op = OP_EVEN_INIT;
                        state_in    = ST_EVEN;
                     end
                     MODE_RR: begin
                        ctrl_cmd.slice_tick = 1'b1;
                        if (dp_status.slice_expire || !dp_status.cur_run) begin
                           ctrl_cmd.op = OP_EVEN_INIT;
                           state_in    = ST_EVEN;
                        end else begin
                           ctrl_cmd.op = OP_RESULT_CUR;
                        end
                     end
                     MODE_AGING: begin
                        ctrl_cmd.op = OP_AGE_INIT;
                        state_in    = ST_AGE;
                     end
                     MODE_RTC: begin
                        if (!dp_status.cur_zero && dp_status.cur_run) begin
                           ctrl_cmd.op = OP_RESULT_CUR;
                        end else begin
                           ctrl_cmd.op = OP_EVEN_INIT;
                           state_in    = ST_EVEN;
                        end
                     end
                  endcase
               end
               CMD_START: begin
                  ctrl_cmd.op = OP_START;
               end
               CMD_RESET: begin
                  if (mode == MODE_RR) begin
                     ctrl_cmd.op = OP_SLICE_LOAD_CUR;
                  end else if (mode == MODE_AGING) begin
                     ctrl_cmd.op = OP_AGE_CLEAR;
                  end
               end
               default: begin
                  ctrl_cmd.op = OP_NONE;
               end
            endcase
         end
         ST_EVEN: begin
            ctrl_cmd.op            = OP_EVEN_STEP;
            ctrl_cmd.slice_on_pick = (mode == MODE_RR);
            if (dp_status.even_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_AGE: begin
            ctrl_cmd.op = OP_AGE_STEP;
            if (dp_status.age_last) begin
               state_in = ST_AGE_FIN;
            end
         end
         ST_AGE_FIN: begin
            ctrl_cmd.op = OP_AGE_FIN;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!dp_status.out_busy) begin
               ctrl_cmd.out_load = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/msps_dpath.sv */
module msps_dpath import msps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      ctrl_cmd,
   input  logic [CMD_W-1:0]  in_cmd,
   input  logic [SLOT_W-1:0] in_slot,
   input  logic [PRIO_W-1:0] in_priority,
   input  logic [MASK_W-1:0] in_mask,
   input  logic [SLOT_W-1:0] in_current,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [SLOT_W-1:0] rsp_next_slot,
   output dp_status_type     dp_status
);

   function automatic logic is_runnable(logic [MASK_W-1:0] mask, logic [SLOT_W-1:0] s);
      return (32'(s) < NUM_SLOTS) && mask[s];
   endfunction

   // item latched at accept
   logic [CMD_W-1:0]  cmd_ff,  cmd_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [SLOT_W-1:0] cur_ff,  cur_in;

   // scheduler state
   logic [PRIO_W-1:0]  prio_tbl_ff [NUM_SLOTS];
   logic [PRIO_W-1:0]  prio_tbl_in [NUM_SLOTS];
   logic [AGE_W-1:0]   age_tbl_ff  [NUM_SLOTS];
   logic [AGE_W-1:0]   age_tbl_in  [NUM_SLOTS];
   logic [SLICE_W-1:0] slice_ff, slice_in;

   // walk registers
   logic [SLOT_W-1:0] idx_ff,       idx_in;
   logic [SLOT_W-1:0] best_ff,      best_in;
   logic [AGE_W-1:0]  best_age_ff,  best_age_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [SLOT_W-1:0] result_ff,    result_in;

   logic              out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0] out_slot_ff,  out_slot_in;

   logic [SLOT_W-1:0]  rd_addr;
   logic [PRIO_W-1:0]  rd_prio;
   logic [AGE_W-1:0]   rd_age;
   logic               cur_run;
   logic               idx_run;
   logic [SLOT_W-1:0]  idx_wrap;
   logic [SLOT_W-1:0]  cur_wrap;
   logic               even_at_cur;
   logic               even_done;
   logic [SLOT_W-1:0]  even_pick;
   logic [AGE_W:0]     age_sum;
   logic [AGE_W-1:0]   age_new;
   logic               age_upd;
   logic               age_better;
   logic [SLICE_W-1:0] slice_dec;

   always_comb begin
      cur_run     = is_runnable(mask_ff, cur_ff);
      idx_run     = is_runnable(mask_ff, idx_ff);
      idx_wrap    = (idx_ff == LAST_SLOT) ? '0 : idx_ff + SLOT_W'(1);
      cur_wrap    = (cur_ff == LAST_SLOT) ? '0 : cur_ff + SLOT_W'(1);
      even_at_cur = (idx_ff == cur_ff);
      even_done   = even_at_cur || ((idx_ff != '0) && idx_run);
      even_pick   = even_at_cur ? (cur_run ? cur_ff : '0) : idx_ff;

      unique case (ctrl_cmd.op)
         OP_SLICE_LOAD_CUR: rd_addr = cur_ff;
         OP_EVEN_STEP:      rd_addr = even_pick;
         OP_AGE_FIN:        rd_addr = best_ff;
         default:           rd_addr = idx_ff;
      endcase
      rd_prio = prio_tbl_ff[rd_addr];
      rd_age  = age_tbl_ff[rd_addr];

      age_sum    = {1'b0, rd_age} + (AGE_W+1)'(rd_prio);
      age_upd    = idx_run && (idx_ff != cur_ff);
      age_new    = age_upd ? (age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0]) : rd_age;
      age_better = idx_run && ((best_ff == '0) || (age_new > best_age_ff) ||
                               ((age_new == best_age_ff) && (rd_prio > best_prio_ff)));

      slice_dec = (slice_ff == '0) ? '0 : slice_ff - SLICE_W'(1);
   end

   always_comb begin
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      prio_in      = prio_ff;
      mask_in      = mask_ff;
      cur_in       = cur_ff;
      prio_tbl_in  = prio_tbl_ff;
      age_tbl_in   = age_tbl_ff;
      slice_in     = slice_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_age_in  = best_age_ff;
      best_prio_in = best_prio_ff;
      result_in    = result_ff;
      out_valid_in = out_valid_ff;
      out_slot_in  = out_slot_ff;

      if (ctrl_cmd.take_in) begin
         cmd_in    = in_cmd;
         slot_in   = in_slot;
         prio_in   = in_priority;
         mask_in   = in_mask;
         // out-of-range current falls back to the idle slot
         cur_in    = (32'(in_current) < NUM_SLOTS) ? in_current : '0;
         result_in = '0;
      end

      if (ctrl_cmd.slice_tick) begin
         slice_in = slice_dec;
      end

      unique case (ctrl_cmd.op)
         OP_START: begin
            if (32'(slot_ff) < NUM_SLOTS) begin
               prio_tbl_in[slot_ff] = prio_ff;
               age_tbl_in[slot_ff]  = '0;
            end
         end
         OP_SLICE_LOAD_CUR: begin
            slice_in = SLICE_W'(rd_prio);
         end
         OP_AGE_CLEAR: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               age_tbl_in[i] = '0;
            end
         end
         OP_RESULT_CUR: begin
            result_in = cur_ff;
         end
         OP_EVEN_INIT: begin
            idx_in = cur_wrap;
         end
         OP_EVEN_STEP: begin
            if (even_done) begin
               result_in = even_pick;
               if (ctrl_cmd.slice_on_pick) begin
                  slice_in = SLICE_W'(rd_prio);
               end
            end else begin
               idx_in = idx_wrap;
            end
         end
         OP_AGE_INIT: begin
            idx_in  = SLOT_W'(1);
            best_in = '0;
         end
         OP_AGE_STEP: begin
            if (age_upd) begin
               age_tbl_in[idx_ff] = age_new;
            end
            if (age_better) begin
               best_in      = idx_ff;
               best_age_in  = age_new;
               best_prio_in = rd_prio;
            end
            idx_in = idx_wrap;
         end
         OP_AGE_FIN: begin
            age_tbl_in[best_ff] = AGE_W'(rd_prio);
            result_in           = best_ff;
         end
         default: begin
         end
      endcase

      if (ctrl_cmd.out_load) begin
         out_valid_in = 1'b1;
         out_slot_in  = result_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            prio_tbl_ff[i] <= '0;
            age_tbl_ff[i]  <= '0;
         end
         slice_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prio_tbl_ff  <= prio_tbl_in;
         age_tbl_ff   <= age_tbl_in;
         slice_ff     <= slice_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      prio_ff      <= prio_in;
      mask_ff      <= mask_in;
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_age_ff  <= best_age_in;
      best_prio_ff <= best_prio_in;
      result_ff    <= result_in;
      out_slot_ff  <= out_slot_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_next_slot = out_slot_ff;

   assign dp_status.cmd          = cmd_ff;
   assign dp_status.cur_run      = cur_run;
   assign dp_status.cur_zero     = (cur_ff == '0);
   assign dp_status.slice_expire = (slice_dec == '0);
   assign dp_status.even_done    = even_done;
   assign dp_status.age_last     = (idx_ff == LAST_SLOT);
   assign dp_status.out_busy     = out_valid_ff && !rsp_ready;

endmodule

/* rtl/multi_strategy_process_scheduler.sv */
// Channel    Dir  Beat payload                                        Handshake
// req_bus    in   cmd, slot, priority_req, runnable_mask, current    valid/ready
// rsp_bus    out  next_slot                                           valid/ready
// csr (APB)  in   strategy_mode at byte address 0                     psel/penable
//
// Sequence: accept, decode, then for a schedule walk the slots one per cycle (up to
// NUM_SLOTS steps for the even pick, NUM_SLOTS-1 plus one for aging), then move
// the result to the output register.
// Reset: synchronous, clears priorities, ages, slice and mode; no clearing pass.
// Stalls: the output register holds a finished beat, so the next request is taken
// while it waits; a new result waits in its finish state until the register frees.
`include "assert_macros.svh"

module multi_strategy_process_scheduler import msps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   msps_req_if.sink              req_bus,
   msps_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   mode_type      mode_ff;
   mode_type      mode_in;
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_write;

   // register file: a single mode register, written on the access phase
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && (csr_index == REG_STRATEGY_MODE)) begin
         mode_in = mode_type'(pwdata[MODE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EVEN;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign prdata = (csr_index == REG_STRATEGY_MODE) ?
                   {{(CSR_DATA_W-MODE_W){1'b0}}, mode_ff} : '0;

   // sequencer: decides which datapath step runs each cycle
   msps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .mode      (mode_ff),
      .dp_status (dp_status),
      .req_ready (req_bus.ready),
      .ctrl_cmd  (ctrl_cmd)
   );

   // tables, slot walk and output register
   msps_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctrl_cmd      (ctrl_cmd),
      .in_cmd        (req_bus.cmd),
      .in_slot       (req_bus.slot),
      .in_priority   (req_bus.priority_req),
      .in_mask       (req_bus.runnable_mask),
      .in_current    (req_bus.current),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_next_slot (rsp_bus.next_slot),
      .dp_status     (dp_status)
   );

   // one item in flight: after an accepted beat, hold off the next
   `ASSERT_NEXT(a_busy_after_accept, req_bus.valid && req_bus.ready, !req_bus.ready)
   // never overwrite a result that has not been taken
   `ASSERT_NOW(a_no_load_while_full, ctrl_cmd.out_load, !rsp_bus.valid || rsp_bus.ready)
   // a finished result shows up on the response channel in the next cycle
   `ASSERT_NEXT(a_rsp_after_load, ctrl_cmd.out_load, rsp_bus.valid)

endmodule
